// ===== hw/rtl/hsc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types, register map and parity helper for the Hamming SEC codec.
// ----------------------------------------------------------------------------
package hsc_pkg;

    localparam int ROW_W      = 11;
    localparam int NUM_ROWS   = 6;
    localparam int CODE_W     = 16;
    localparam int DATA_W     = 11;
    localparam int STATUS_W   = 2;
    localparam int EPOS_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_PARITY_ROW_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARITY_ROW_5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SEC_DED      = 3'd6;

    // decode status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CORRECTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    typedef logic [NUM_ROWS-1:0][ROW_W-1:0] row_array_t;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [DATA_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic [EPOS_W-1:0]   epos;
    } result_t;

    // One check bit per active parity row; rows at or above nrows give zero.
    function automatic logic [NUM_ROWS-1:0] check_bits(
        input row_array_t        rows,
        input logic [ROW_W-1:0]  data,
        input int unsigned       nrows
    );
        logic [NUM_ROWS-1:0] c;
        c = '0;
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (i < nrows)
            begin
                c[i] = ^(rows[i] & data);
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/hamming_sec_codec_top.sv =====
// ----------------------------------------------------------------------------
// hamming_sec_codec_top
// Systematic Hamming SEC / SEC-DED codec with a programmable parity matrix.
// ----------------------------------------------------------------------------
// One transaction per clock, sustained while out_ready stays high. An input
// goes into the input register, through one pass of XOR trees and parallel
// column compares, then into the result register. A result left waiting on
// the output does not block the next input until the input register is also
// full. The parity rows and SEC-DED flag reset to zero; the user must write
// them through cfg_we / cfg_index / cfg_data only while the codec is idle;
// the block does not enforce it. Indices beyond the register map are ignored.
// ----------------------------------------------------------------------------
module hamming_sec_codec_top
    import hsc_pkg::*;
#(
    parameter int PARITY_BITS = 4,
    parameter int DATA_BITS   = 11
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic [DATA_W-1:0]     data_word,
    input  logic [CODE_W-1:0]     code_word,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CODE_W-1:0]     code_out,
    output logic [DATA_W-1:0]     data_out,
    output logic [STATUS_W-1:0]   status,
    output logic [EPOS_W-1:0]     error_position
);

    row_array_t        rows_reg;
    logic              sec_ded_reg;

    logic              s1_valid_reg;
    logic              s1_action_reg;
    logic [DATA_W-1:0] s1_data_reg;
    logic [CODE_W-1:0] s1_code_reg;

    logic              out_valid_reg;
    result_t           out_reg;

    logic              out_advance;
    logic [CODE_W-1:0] enc_code;
    result_t           dec_result;
    result_t           result_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg    <= '0;
            sec_ded_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index) inside
                [REG_PARITY_ROW_0:REG_PARITY_ROW_5]:
                begin
                    rows_reg[cfg_index] <= cfg_data[ROW_W-1:0];
                end
                REG_SEC_DED:
                begin
                    sec_ded_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_advance = !out_valid_reg || out_ready;
    assign in_ready    = !s1_valid_reg || out_advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_action_reg <= action;
            s1_data_reg   <= data_word;
            s1_code_reg   <= code_word;
        end
    end

    hsc_encoder #(
        .PARITY_BITS (PARITY_BITS),
        .DATA_BITS   (DATA_BITS)
    ) u_encoder (
        .rows      (rows_reg),
        .sec_ded   (sec_ded_reg),
        .data_word (s1_data_reg),
        .code_out  (enc_code)
    );

    hsc_decoder #(
        .PARITY_BITS (PARITY_BITS),
        .DATA_BITS   (DATA_BITS)
    ) u_decoder (
        .rows      (rows_reg),
        .code_word (s1_code_reg),
        .result    (dec_result)
    );

    always_comb
    begin
        if (s1_action_reg)
        begin
            result_next = dec_result;
        end
        else
        begin
            result_next        = '0;
            result_next.code   = enc_code;
            result_next.status = STATUS_OK;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && s1_valid_reg)
        begin
            out_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign code_out       = out_reg.code;
    assign data_out       = out_reg.data;
    assign status         = out_reg.status;
    assign error_position = out_reg.epos;

endmodule

// ===== hw/rtl/hsc_encoder.sv =====
// ----------------------------------------------------------------------------
// hsc_encoder
// Systematic encoder: check bits below the data, optional overall parity.
// ----------------------------------------------------------------------------
module hsc_encoder
    import hsc_pkg::*;
#(
    parameter int PARITY_BITS = 4,
    parameter int DATA_BITS   = 11
)
(
    input  row_array_t         rows,
    input  logic               sec_ded,
    input  logic [DATA_W-1:0]  data_word,
    output logic [CODE_W-1:0]  code_out
);

    localparam int CODE_BITS = PARITY_BITS + DATA_BITS;
    localparam int DE        = (DATA_BITS < ROW_W) ? DATA_BITS : ROW_W;
    localparam int W         = PARITY_BITS + ROW_W;
    localparam logic [ROW_W-1:0] DMASK = ROW_W'((64'd1 << DE) - 64'd1);

    logic [ROW_W-1:0]    data_m;
    logic [NUM_ROWS-1:0] chk;
    logic [W-1:0]        cw;
    logic                parity;
    logic [63:0]         wide;

    always_comb
    begin
        data_m = data_word & DMASK;
        chk    = check_bits(rows, data_m, PARITY_BITS);
        cw     = {data_m, chk[PARITY_BITS-1:0]};
        parity = ^cw;
        wide   = 64'(cw);
        // overall parity sits at bit n; falls off the port when n >= 16
        if (sec_ded)
        begin
            wide = wide | (64'(parity) << CODE_BITS);
        end
        code_out = wide[CODE_W-1:0];
    end

endmodule

// ===== hw/rtl/hsc_decoder.sv =====
// ----------------------------------------------------------------------------
// hsc_decoder
// Syndrome, first-match column search over H = [I | P] and single-bit fix.
// ----------------------------------------------------------------------------
module hsc_decoder
    import hsc_pkg::*;
#(
    parameter int PARITY_BITS = 4,
    parameter int DATA_BITS   = 11
)
(
    input  row_array_t         rows,
    input  logic [CODE_W-1:0]  code_word,
    output result_t            result
);

    localparam int CODE_BITS = PARITY_BITS + DATA_BITS;
    localparam int DE        = (DATA_BITS < ROW_W) ? DATA_BITS : ROW_W;
    localparam int W         = PARITY_BITS + ROW_W;
    localparam int POS_W     = $clog2(W);
    localparam logic [ROW_W-1:0] DMASK = ROW_W'((64'd1 << DE) - 64'd1);
    localparam logic [63:0] CMASK =
        (CODE_BITS >= 64) ? '1 : ((64'd1 << CODE_BITS) - 64'd1);

    logic [63:0]            cw_wide;
    logic [W-1:0]           cw;
    logic [W-1:0]           cw_fix;
    logic [ROW_W-1:0]       data_in;
    logic [NUM_ROWS-1:0]    chk;
    logic [PARITY_BITS-1:0] syn;
    logic [PARITY_BITS-1:0] col;
    logic [ROW_W-1:0]       match;
    logic                   found;
    logic [POS_W-1:0]       pos;
    logic [63:0]            out_wide;

    always_comb
    begin
        cw_wide = 64'(code_word) & CMASK;
        cw      = cw_wide[W-1:0];
        data_in = cw[W-1:PARITY_BITS] & DMASK;
        chk     = check_bits(rows, data_in, PARITY_BITS);
        syn     = cw[PARITY_BITS-1:0] ^ chk[PARITY_BITS-1:0];

        // parallel compare against every data column; zero columns never hit
        match = '0;
        for (int q = 0; q < ROW_W; q++)
        begin
            for (int i = 0; i < PARITY_BITS; i++)
            begin
                col[i] = rows[i][q];
            end
            match[q] = (q < DE) && (syn != '0) && (col == syn);
        end

        found = 1'b0;
        pos   = '0;
        if ($onehot(syn))
        begin
            // unit column wins over any data column of the same pattern
            found = 1'b1;
            for (int i = PARITY_BITS - 1; i >= 0; i--)
            begin
                if (syn[i])
                begin
                    pos = POS_W'(i);
                end
            end
        end
        else if (|match)
        begin
            found = 1'b1;
            for (int q = ROW_W - 1; q >= 0; q--)
            begin
                if (match[q])
                begin
                    pos = POS_W'(PARITY_BITS + q);
                end
            end
        end

        cw_fix = cw;
        if (found)
        begin
            cw_fix = cw ^ (W'(1) << pos);
        end

        out_wide      = 64'(cw_fix);
        result.code   = out_wide[CODE_W-1:0];
        result.data   = cw_fix[W-1:PARITY_BITS] & DMASK;
        result.epos   = found ? EPOS_W'(pos) : '0;
        if (syn == '0)
        begin
            result.status = STATUS_OK;
        end
        else if (found)
        begin
            result.status = STATUS_CORRECTED;
        end
        else
        begin
            result.status = STATUS_NOT_FOUND;
        end
    end

endmodule

// ===== hw/rtl/hsc_checker.sv =====
// ----------------------------------------------------------------------------
// hsc_checker
// Port-level checks on the codec, bound to the top level.
// ----------------------------------------------------------------------------
module hsc_checker
    import hsc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [CODE_W-1:0]     code_out,
    input logic [DATA_W-1:0]     data_out,
    input logic [STATUS_W-1:0]   status,
    input logic [EPOS_W-1:0]     error_position
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_out)
            && $stable(data_out) && $stable(status) && $stable(error_position))
        else $error("result changed while stalled");

    // an empty output stage never backpressures the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with output stage empty");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_CORRECTED
            || status == STATUS_NOT_FOUND))
        else $error("undefined status code");

    a_epos_only_corrected: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_CORRECTED |-> error_position == '0)
        else $error("error position set without correction");

endmodule

bind hamming_sec_codec_top hsc_checker u_hsc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .code_out       (code_out),
    .data_out       (data_out),
    .status         (status),
    .error_position (error_position)
);
